[rtl/core/skt_pkg.sv]
// Shared types and constants for the sorted key table.
// Used by skt_engine and sorted_key_table; depends on nothing else.
package skt_pkg;

    // Fixed field widths of the stream words
    localparam int OP_W       = 2;
    localparam int KEY_W      = 32;
    localparam int POS_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 11;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    // Default sizing of the table
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_BITS_DEF    = 32;

    // Operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Result status codes carried in the output tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    // One finished result handed from the engine to the output register
    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

endpackage

[rtl/core/skt_engine.sv]
// Operation sequencer for the sorted key table: binary search, shifting
// insert and delete, positional read. Drives the key memory held in the top
// level. Depends on skt_pkg.
module skt_engine #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // operation in
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  skt_pkg::t_op               i_op,
    input  logic [KEY_BITS-1:0]        i_key,
    input  logic [skt_pkg::POS_W-1:0]  i_pos,
    // key memory port
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [KEY_BITS-1:0]        i_rd_data,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [KEY_BITS-1:0]        o_wr_data,
    // result out
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output skt_pkg::t_result           o_res
);

    localparam int PW    = skt_pkg::POS_W;
    localparam int VAL_W = skt_pkg::VALUE_W;
    localparam int CNT_W = skt_pkg::COUNT_W;
    localparam int PCW   = CW + PW;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SRCH_STEP = 9'b000000010,
        S_SRCH_CMP  = 9'b000000100,
        S_INS_CMP   = 9'b000001000,
        S_INS_PUT   = 9'b000010000,
        S_DEL_FIND  = 9'b000100000,
        S_DEL_SHIFT = 9'b001000000,
        S_RD_WAIT   = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

    t_state                r_state,  n_state;
    logic [KEY_BITS-1:0]   r_key,    n_key;
    logic [CW-1:0]         r_lo,     n_lo;
    logic [CW-1:0]         r_hi,     n_hi;
    logic [CW-1:0]         r_idx,    n_idx;
    logic [CW-1:0]         r_count,  n_count;
    skt_pkg::t_status      r_status, n_status;
    logic [KEY_BITS-1:0]   r_value,  n_value;

    logic [CW-1:0]         w_mid;
    logic [CW-1:0]         w_idx_p1;
    logic [CW-1:0]         w_idx_p2;
    logic [CW-1:0]         w_idx_m1;
    logic                  w_rd_lt_key;
    logic                  w_rd_gt_key;
    logic                  w_rd_eq_key;
    logic                  w_pos_ok;

    // Index arithmetic and key comparison on the word read last cycle
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_idx_p1    = r_idx + ONE_C;
    assign w_idx_p2    = r_idx + TWO_C;
    assign w_idx_m1    = r_idx - ONE_C;
    assign w_rd_lt_key = $signed(i_rd_data) <  $signed(r_key);
    assign w_rd_gt_key = $signed(i_rd_data) >  $signed(r_key);
    assign w_rd_eq_key = i_rd_data == r_key;
    assign w_pos_ok    = PCW'(i_pos) < PCW'(r_count);

    assign o_in_ready  = r_state == S_IDLE;
    assign o_res_valid = (r_state == S_OUT) && i_res_ready;
    assign o_res.status      = r_status;
    assign o_res.value       = VAL_W'(r_value);
    assign o_res.entry_count = CNT_W'(r_count);

    // Next state, memory requests and result
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_idx     = r_idx;
        n_count   = r_count;
        n_status  = r_status;
        n_value   = r_value;
        o_rd_en   = 1'b0;
        o_rd_addr = AW'(r_idx);
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_idx);
        o_wr_data = r_key;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = i_key;
                    n_status = skt_pkg::STAT_OK;
                    n_value  = '0;
                    case (i_op)
                        skt_pkg::OP_SEARCH: begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_SRCH_STEP;
                        end
                        skt_pkg::OP_INSERT: begin
                            n_idx = r_count;
                            if (r_count >= DEPTH_C) begin
                                n_status = skt_pkg::STAT_FULL;
                                n_state  = S_OUT;
                            end else if (r_count == '0) begin
                                n_state = S_INS_PUT;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(r_count - ONE_C);
                                n_state   = S_INS_CMP;
                            end
                        end
                        skt_pkg::OP_DELETE: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_status = skt_pkg::STAT_MISS;
                                n_state  = S_OUT;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = S_DEL_FIND;
                            end
                        end
                        default: begin
                            if (w_pos_ok) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(i_pos);
                                n_state   = S_RD_WAIT;
                            end else begin
                                n_status = skt_pkg::STAT_RANGE;
                                n_state  = S_OUT;
                            end
                        end
                    endcase
                end
            end

            // Probe the middle of the open range [lo, hi)
            S_SRCH_STEP: begin
                if (r_lo < r_hi) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_mid);
                    n_idx     = w_mid;
                    n_state   = S_SRCH_CMP;
                end else begin
                    n_status = skt_pkg::STAT_MISS;
                    n_state  = S_OUT;
                end
            end

            S_SRCH_CMP: begin
                if (w_rd_eq_key) begin
                    n_value = r_key;
                    n_state = S_OUT;
                end else begin
                    if (w_rd_lt_key) begin
                        n_lo = w_idx_p1;
                    end else begin
                        n_hi = r_idx;
                    end
                    n_state = S_SRCH_STEP;
                end
            end

            // Move greater keys up one slot; read of idx-2 overlaps write of idx
            S_INS_CMP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_idx);
                if (w_rd_gt_key) begin
                    o_wr_data = i_rd_data;
                    n_idx     = w_idx_m1;
                    if (w_idx_m1 == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(r_idx - TWO_C);
                    end
                end else begin
                    o_wr_data = r_key;
                    n_count   = r_count + ONE_C;
                    n_state   = S_OUT;
                end
            end

            S_INS_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_idx);
                o_wr_data = r_key;
                n_count   = r_count + ONE_C;
                n_state   = S_OUT;
            end

            // Scan upward for the first equal key, one entry a cycle
            S_DEL_FIND: begin
                o_rd_addr = AW'(w_idx_p1);
                o_rd_en   = w_idx_p1 < r_count;
                if (w_rd_eq_key) begin
                    if (w_idx_p1 < r_count) begin
                        n_state = S_DEL_SHIFT;
                    end else begin
                        n_count = r_count - ONE_C;
                        n_state = S_OUT;
                    end
                end else if (w_idx_p1 < r_count) begin
                    n_idx = w_idx_p1;
                end else begin
                    n_status = skt_pkg::STAT_MISS;
                    n_state  = S_OUT;
                end
            end

            // Move later keys down one slot; read of idx+2 overlaps write of idx
            S_DEL_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_idx);
                o_wr_data = i_rd_data;
                o_rd_addr = AW'(w_idx_p2);
                o_rd_en   = w_idx_p2 < r_count;
                n_idx     = w_idx_p1;
                if (!(w_idx_p2 < r_count)) begin
                    n_count = r_count - ONE_C;
                    n_state = S_OUT;
                end
            end

            S_RD_WAIT: begin
                n_value = i_rd_data;
                n_state = S_OUT;
            end

            // Hold the result until the output register can take it
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_value  <= n_value;
    end

    // A read never targets the entry written in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_en && o_wr_en) |-> (o_rd_addr != o_wr_addr))
        else $error("key memory read and write hit the same entry");

    // The count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("key count beyond table depth");

    // The table only changes while an insert or delete is under way
    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_INS_CMP || r_state == S_INS_PUT ||
                     r_state == S_DEL_SHIFT))
        else $error("key memory written outside an update");

    // The count moves by at most one per item, and only as a result is formed
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_state == S_OUT))
        else $error("key count changed without a result");

    // Search range stays ordered
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CMP) |-> (r_lo <= r_idx && r_idx < r_hi))
        else $error("binary search probe outside its range");

endmodule

[rtl/core/sorted_key_table.sv]
// Sorted key table: stream ports, key memory and output register.
// Depends on skt_pkg and skt_engine.
//
// Usage: each input word is one operation (search, insert, delete, read at
// position), given in s_axis_tuser; key and position travel in s_axis_tdata.
// Each operation gives exactly one output word with a status in m_axis_tuser
// and the value and the count of keys held in m_axis_tdata.
// Keys live in a single-port-read, single-port-write memory of TABLE_DEPTH
// entries with a registered read; the sequencer walks it one entry
// per cycle.
// The time from acceptance to the output word grows with the number of
// halving steps for a search, with the number of greater keys moved up
// for an insert, and with the position of the match and the number of
// keys moved down for a delete.
// One operation is in flight at a time; s_axis_tready rises again as soon as
// the result enters the output register, so the next word is taken while
// the previous result waits. When the receiver stalls, the result is held
// in the output register and a second finished result waits in the engine.
// Reset empties the table at once: the count goes to zero, no clearing pass.
module sorted_key_table #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key [31:0], position [41:32], zero [47:42]
    input  logic [skt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // operation [1:0]
    input  logic [skt_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // value [31:0], entry_count [42:32], zero [47:43]
    output logic [skt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [skt_pkg::STATUS_W-1:0]       m_axis_tuser
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int KW    = skt_pkg::KEY_W;
    localparam int PW    = skt_pkg::POS_W;
    localparam int VAL_W = skt_pkg::VALUE_W;
    localparam int CNT_W = skt_pkg::COUNT_W;
    localparam int PAD_W = skt_pkg::M_TDATA_W - VAL_W - CNT_W;

    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [KEY_BITS-1:0]   w_wr_data;
    logic                  w_res_valid;
    logic                  w_res_ready;
    skt_pkg::t_result      w_res;

    logic [KEY_BITS-1:0]   r_key_store [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   r_rd_data;
    logic                  r_m_valid;
    skt_pkg::t_result      r_m_res;

    // Output register is free when empty or being drained
    assign w_res_ready = !r_m_valid || m_axis_tready;

    skt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (skt_pkg::t_op'(s_axis_tuser)),
        .i_key       (KEY_BITS'(s_axis_tdata[KW-1:0])),
        .i_pos       (s_axis_tdata[KW+PW-1:KW]),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (r_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Key memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_key_store[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_key_store[w_rd_addr];
        end
    end

    // Output word valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_m_res.entry_count, r_m_res.value};

endmodule
